// File: rtl/dq_pkg.sv
// Shared constants, codes and controller/datapath types for the double-ended queue.
package dq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int VALUE_W       = 32;
   localparam int KIND_W        = 3;
   localparam int STATUS_W      = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_BACK   = 3'd0,
      KIND_PUSH_FRONT  = 3'd1,
      KIND_POP_BACK    = 3'd2,
      KIND_POP_FRONT   = 3'd3,
      KIND_WRITE_FRONT = 3'd4,
      KIND_WRITE_BACK  = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_FETCH,
      STATE_DONE
   } state_type;

   typedef struct packed {
      logic exec;
      logic fetch;
      logic publish;
   } dq_cmd_type;

   typedef struct packed {
      logic need_fetch;
   } dq_stat_type;

endpackage

// File: rtl/dq_if.sv
// Request and response channel interfaces of the double-ended queue.
interface dq_req_if
   import dq_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

interface dq_rsp_if
   import dq_pkg::*;
#(
   parameter int CNT_W = $clog2(DEPTH_DEFAULT + 1)
) ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] popped_value;
   logic signed [VALUE_W-1:0] front_value;
   logic signed [VALUE_W-1:0] back_value;
   logic [CNT_W-1:0]          entry_count;
   logic [STATUS_W-1:0]       status;

   modport source (output valid, output popped_value, output front_value,
                   output back_value, output entry_count, output status, input ready);
   modport sink   (input valid, input popped_value, input front_value,
                   input back_value, input entry_count, input status, output ready);
endinterface

// File: rtl/dq_ctrl.sv
// Sequencing state machine: accept, optional store fetch, result hand-off.
module dq_ctrl
   import dq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dq_stat_type stat,
   output dq_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STATE_IDLE: begin
            if (req_valid) begin
               state_in = stat.need_fetch ? STATE_FETCH : STATE_DONE;
            end
         end
         STATE_FETCH: begin
            state_in = STATE_DONE;
         end
         STATE_DONE: begin
            if (slot_free) begin
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = (state_ff == STATE_IDLE);
      cmd.exec    = (state_ff == STATE_IDLE) && req_valid;
      cmd.fetch   = (state_ff == STATE_FETCH);
      cmd.publish = (state_ff == STATE_DONE) && slot_free;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/dq_dpath.sv
// Ring store, head/count pointers, cached end values and result word register.
module dq_dpath
   import dq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int IDX_W = $clog2(DEPTH),
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dq_cmd_type                cmd,
   output dq_stat_type               stat,
   input  logic [KIND_W-1:0]         kind,
   input  logic signed [VALUE_W-1:0] value,
   output logic signed [VALUE_W-1:0] popped_value,
   output logic signed [VALUE_W-1:0] front_value,
   output logic signed [VALUE_W-1:0] back_value,
   output logic [CNT_W-1:0]          entry_count,
   output logic [STATUS_W-1:0]       status
);

   localparam int SUM_W = CNT_W + 1;

   logic [VALUE_W-1:0] store_ff [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   logic [IDX_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [VALUE_W-1:0] front_ff, front_in;
   logic [VALUE_W-1:0] back_ff, back_in;
   logic [VALUE_W-1:0] popped_ff, popped_in;
   status_type         status_ff, status_in;
   logic               fetch_back_ff, fetch_back_in;

   logic [VALUE_W-1:0] popped_out_ff;
   logic [VALUE_W-1:0] front_out_ff;
   logic [VALUE_W-1:0] back_out_ff;
   logic [CNT_W-1:0]   count_out_ff;
   logic [STATUS_W-1:0] status_out_ff;

   logic               wr_en, rd_en;
   logic [IDX_W-1:0]   wr_addr, rd_addr;
   logic [VALUE_W-1:0] wr_data;

   logic [SUM_W-1:0]   head_x, count_x, tail_sum;
   logic [IDX_W-1:0]   tail_idx, back_idx, prev_idx, head_inc, head_dec;
   logic               empty, full, single;

   function automatic logic [IDX_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] t;
      t = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
      return t[IDX_W-1:0];
   endfunction

   assign head_x   = {{(SUM_W-IDX_W){1'b0}}, head_ff};
   assign count_x  = {1'b0, count_ff};
   assign tail_sum = head_x + count_x;
   assign tail_idx = ring_wrap(tail_sum);
   assign back_idx = ring_wrap(tail_sum - SUM_W'(1));
   assign prev_idx = ring_wrap(tail_sum - SUM_W'(2));
   assign head_inc = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
   assign head_dec = (head_ff == '0) ? IDX_W'(DEPTH - 1) : head_ff - IDX_W'(1);
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign single   = (count_ff == CNT_W'(1));

   always_comb begin
      head_in         = head_ff;
      count_in        = count_ff;
      front_in        = front_ff;
      back_in         = back_ff;
      popped_in       = popped_ff;
      status_in       = status_ff;
      fetch_back_in   = fetch_back_ff;
      wr_en           = 1'b0;
      wr_addr         = head_ff;
      wr_data         = value;
      rd_en           = 1'b0;
      rd_addr         = head_inc;
      stat.need_fetch = 1'b0;
      if (cmd.exec) begin
         popped_in = '0;
         status_in = STATUS_OK;
         unique case (kind)
            KIND_PUSH_BACK: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = tail_idx;
                  count_in = count_ff + CNT_W'(1);
                  back_in  = value;
                  if (empty) begin
                     front_in = value;
                  end
               end
            end
            KIND_PUSH_FRONT: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = head_dec;
                  head_in  = head_dec;
                  count_in = count_ff + CNT_W'(1);
                  front_in = value;
                  if (empty) begin
                     back_in = value;
                  end
               end
            end
            KIND_POP_BACK: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  popped_in = back_ff;
                  count_in  = count_ff - CNT_W'(1);
                  if (!single) begin
                     rd_en           = 1'b1;
                     rd_addr         = prev_idx;
                     fetch_back_in   = 1'b1;
                     stat.need_fetch = 1'b1;
                  end
               end
            end
            KIND_POP_FRONT: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  popped_in = front_ff;
                  head_in   = head_inc;
                  count_in  = count_ff - CNT_W'(1);
                  if (!single) begin
                     rd_en           = 1'b1;
                     rd_addr         = head_inc;
                     fetch_back_in   = 1'b0;
                     stat.need_fetch = 1'b1;
                  end
               end
            end
            KIND_WRITE_FRONT: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = head_ff;
                  front_in = value;
                  if (single) begin
                     back_in = value;
                  end
               end
            end
            KIND_WRITE_BACK: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = back_idx;
                  back_in = value;
                  if (single) begin
                     front_in = value;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (cmd.fetch) begin
         if (fetch_back_ff) begin
            back_in = rd_data_ff;
         end else begin
            front_in = rd_data_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff      <= front_in;
      back_ff       <= back_in;
      popped_ff     <= popped_in;
      status_ff     <= status_in;
      fetch_back_ff <= fetch_back_in;
      if (cmd.publish) begin
         popped_out_ff <= popped_ff;
         front_out_ff  <= empty ? '0 : front_ff;
         back_out_ff   <= empty ? '0 : back_ff;
         count_out_ff  <= count_ff;
         status_out_ff <= status_ff;
      end
   end

   assign popped_value = popped_out_ff;
   assign front_value  = front_out_ff;
   assign back_value   = back_out_ff;
   assign entry_count  = count_out_ff;
   assign status       = status_out_ff;

endmodule

// File: rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit values.
//
// Usage: one request word on req_chan carries an operation kind (push back/front,
// pop back/front, overwrite front/back) and a value. Each request yields exactly
// one response word on rsp_chan: the popped value, the front and back values and
// the element count after the operation, and a status (ok, empty, full).
// Sequencing: a request is executed when it is accepted in IDLE; the response
// registers on rsp_chan are loaded when DONE publishes. DONE is entered straight
// from IDLE or, for a pop that leaves one or more elements, through FETCH, since
// the new end value is fetched through the store's registered read port. req_ready
// is high only in IDLE, so a new request is taken only after the last leaves DONE.
// A request may be taken while the previous response still waits on rsp_chan;
// it is then held finished until the response register frees. While the
// receiver stalls, rsp_chan holds its word and req_ready stays low after that.
// Reset empties the queue (head and count cleared); the store is not cleared
// and needs no clearing pass, entries being read only after they are written.
module double_ended_queue
   import dq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int IDX_W = $clog2(DEPTH),
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic     clock,
   input  logic     reset,
   dq_req_if.sink   req_chan,
   dq_rsp_if.source rsp_chan
);

   dq_cmd_type  cmd;
   dq_stat_type stat;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dq_dpath #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .kind         (req_chan.kind),
      .value        (req_chan.value),
      .popped_value (rsp_chan.popped_value),
      .front_value  (rsp_chan.front_value),
      .back_value   (rsp_chan.back_value),
      .entry_count  (rsp_chan.entry_count),
      .status       (rsp_chan.status)
   );

endmodule

// File: rtl/dq_checker.sv
// Port-level assertions for the double-ended queue, bound to the top level.
module dq_checker
   import dq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [VALUE_W-1:0] popped_value,
   input logic signed [VALUE_W-1:0] front_value,
   input logic signed [VALUE_W-1:0] back_value,
   input logic [CNT_W-1:0]          entry_count,
   input logic [STATUS_W-1:0]       status
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> entry_count <= CNT_W'(DEPTH))
      else $error("element count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && entry_count == '0 |-> front_value == '0 && back_value == '0)
      else $error("empty queue reports non-zero end values");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STATUS_EMPTY |-> entry_count == '0 && popped_value == '0)
      else $error("empty status on a non-empty queue");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STATUS_FULL |-> entry_count == CNT_W'(DEPTH) &&
      popped_value == '0)
      else $error("full status on a queue that is not full");

endmodule

bind double_ended_queue dq_checker #(
   .DEPTH (DEPTH),
   .CNT_W (CNT_W)
) u_dq_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .popped_value (rsp_chan.popped_value),
   .front_value  (rsp_chan.front_value),
   .back_value   (rsp_chan.back_value),
   .entry_count  (rsp_chan.entry_count),
   .status       (rsp_chan.status)
);

// File: tb/tb_top.sv
// Self-checking testbench for the double-ended queue: predicted responses versus DUT output.
module tb_top;
   import dq_pkg::*;

   localparam int QDEPTH = DEPTH_DEFAULT;
   localparam int IDX_W  = $clog2(QDEPTH);
   localparam int CNT_W  = $clog2(QDEPTH + 1);
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PHASE_ITEMS    = 300;

   localparam logic [KIND_W-1:0] KIND_UNUSED_A = 3'd6;
   localparam logic [KIND_W-1:0] KIND_UNUSED_B = 3'd7;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic signed [VALUE_W-1:0] value;
   } dq_op_type;

   typedef struct {
      logic signed [VALUE_W-1:0] popped;
      logic signed [VALUE_W-1:0] front;
      logic signed [VALUE_W-1:0] back;
      logic [CNT_W-1:0]          count;
      status_type                status;
   } dq_result_type;

   logic clock;
   logic reset;

   dq_req_if                  req_chan ();
   dq_rsp_if #(.CNT_W(CNT_W)) rsp_chan ();

   double_ended_queue dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   dq_op_type     op_backlog[$];
   dq_result_type due_results[$];

   logic signed [VALUE_W-1:0] shadow_store [QDEPTH];
   logic [IDX_W-1:0]          shadow_head;
   int                        shadow_count;

   int send_idle_pct;
   int recv_stall_pct;
   int error_count;
   int ops_accepted;
   int words_checked;
   int full_refusals;
   int empty_refusals;
   int unknown_ops;
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [IDX_W-1:0] ring_slot(input int offset);
      return IDX_W'((int'(shadow_head) + offset) % QDEPTH);
   endfunction

   // mostly random patterns, with the sign and range extremes mixed in
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(15))
         0:       return VALUE_MAX;
         1:       return VALUE_MIN;
         2:       return '1;
         3:       return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic void enqueue_op(input logic [KIND_W-1:0] kind,
                                      input logic signed [VALUE_W-1:0] value);
      dq_op_type op;
      op.kind  = kind;
      op.value = value;
      op_backlog.insert(op_backlog.size(), op);
   endfunction

   task automatic apply_operation(input logic [KIND_W-1:0] kind,
                                  input logic signed [VALUE_W-1:0] value);
      dq_result_type res;
      res.popped = '0;
      res.status = STATUS_OK;
      case (kind)
         KIND_PUSH_BACK: begin
            if (shadow_count >= QDEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               shadow_store[ring_slot(shadow_count)] = value;
               shadow_count++;
            end
         end
         KIND_PUSH_FRONT: begin
            if (shadow_count >= QDEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               shadow_head = ring_slot(QDEPTH - 1);
               shadow_store[shadow_head] = value;
               shadow_count++;
            end
         end
         KIND_POP_BACK: begin
            if (shadow_count == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.popped = shadow_store[ring_slot(shadow_count - 1)];
               shadow_count--;
            end
         end
         KIND_POP_FRONT: begin
            if (shadow_count == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.popped = shadow_store[ring_slot(0)];
               shadow_head = ring_slot(1);
               shadow_count--;
            end
         end
         KIND_WRITE_FRONT: begin
            if (shadow_count == 0) res.status = STATUS_EMPTY;
            else shadow_store[ring_slot(0)] = value;
         end
         KIND_WRITE_BACK: begin
            if (shadow_count == 0) res.status = STATUS_EMPTY;
            else shadow_store[ring_slot(shadow_count - 1)] = value;
         end
         default: begin
            unknown_ops++;
         end
      endcase
      if (shadow_count == 0) begin
         res.front = '0;
         res.back  = '0;
      end else begin
         res.front = shadow_store[ring_slot(0)];
         res.back  = shadow_store[ring_slot(shadow_count - 1)];
      end
      res.count = CNT_W'(shadow_count);
      if (res.status == STATUS_FULL) full_refusals++;
      if (res.status == STATUS_EMPTY) empty_refusals++;
      due_results.insert(due_results.size(), res);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH word %0d: %s got %0h expected %0h", words_checked, what, got, want);
      error_count++;
   endtask

   // runs of filling, draining or mixed traffic so that both full and empty are hit often
   task automatic queue_random_ops(input int total);
      int lean, run, pick, push_pct, pop_pct;
      while (total > 0) begin
         lean     = $urandom_range(2);
         run      = $urandom_range(8, 40);
         push_pct = (lean == 0) ? 65 : (lean == 1) ? 15 : 40;
         pop_pct  = 80 - push_pct;
         repeat (run) begin
            if (total > 0) begin
               pick = $urandom_range(99);
               if (pick < push_pct)
                  enqueue_op($urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, pick_value());
               else if (pick < push_pct + pop_pct)
                  enqueue_op($urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK, pick_value());
               else if (pick < 97)
                  enqueue_op($urandom_range(1) ? KIND_WRITE_FRONT : KIND_WRITE_BACK,
                             pick_value());
               else
                  enqueue_op($urandom_range(1) ? KIND_UNUSED_A : KIND_UNUSED_B, pick_value());
               total--;
            end
         end
      end
   endtask

   task automatic wait_all_answered();
      do @(negedge clock);
      while (op_backlog.size() != 0 || req_chan.valid || due_results.size() != 0);
   endtask

   always @(posedge clock) begin : driver
      dq_op_type word;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            apply_operation(req_chan.kind, req_chan.value);
            ops_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               word = op_backlog[0];
               op_backlog.delete(0);
               req_chan.valid <= 1'b1;
               req_chan.kind  <= word.kind;
               req_chan.value <= word.value;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      dq_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (due_results.size() == 0) begin
               report_mismatch("unexpected word", rsp_chan.popped_value, '0);
            end else begin
               want = due_results[0];
               due_results.delete(0);
               if (rsp_chan.popped_value !== want.popped)
                  report_mismatch("popped_value", rsp_chan.popped_value, want.popped);
               if (rsp_chan.front_value !== want.front)
                  report_mismatch("front_value", rsp_chan.front_value, want.front);
               if (rsp_chan.back_value !== want.back)
                  report_mismatch("back_value", rsp_chan.back_value, want.back);
               if (rsp_chan.entry_count !== want.count)
                  report_mismatch("entry_count", 32'(rsp_chan.entry_count), 32'(want.count));
               if (rsp_chan.status !== want.status)
                  report_mismatch("status", 32'(rsp_chan.status), 32'(want.status));
            end
            words_checked++;
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                  quiet_cycles, due_results.size());
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int idle_plan [4];
      int stall_plan [4];
      idle_plan  = '{0, 69, 0, 20};
      stall_plan = '{0, 0, 69, 20};
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.kind  = '0;
      req_chan.value = '0;
      rsp_chan.ready = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      error_count    = 0;
      ops_accepted   = 0;
      words_checked  = 0;
      full_refusals  = 0;
      empty_refusals = 0;
      unknown_ops    = 0;
      quiet_cycles   = 0;
      shadow_head    = '0;
      shadow_count   = 0;
      foreach (shadow_store[i]) shadow_store[i] = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty-queue refusals and spare codes, fill to full, refusals on full, then overwrite and pop both ends
      enqueue_op(KIND_POP_BACK, VALUE_MAX);
      enqueue_op(KIND_POP_FRONT, VALUE_MIN);
      enqueue_op(KIND_WRITE_FRONT, VALUE_MAX);
      enqueue_op(KIND_WRITE_BACK, VALUE_MIN);
      enqueue_op(KIND_UNUSED_A, '1);
      enqueue_op(KIND_UNUSED_B, '0);
      for (int i = 0; i < QDEPTH; i++)
         enqueue_op((i % 2) ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
                    (i == 0) ? VALUE_MAX : (i == 1) ? VALUE_MIN :
                    (i == 2) ? '1 : (i == 3) ? '0 : pick_value());
      enqueue_op(KIND_PUSH_BACK, pick_value());
      enqueue_op(KIND_PUSH_FRONT, pick_value());
      enqueue_op(KIND_WRITE_FRONT, VALUE_MIN);
      enqueue_op(KIND_WRITE_BACK, VALUE_MAX);
      enqueue_op(KIND_POP_BACK, '0);
      enqueue_op(KIND_POP_FRONT, '1);
      wait_all_answered();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = idle_plan[p];
         recv_stall_pct = stall_plan[p];
         queue_random_ops(PHASE_ITEMS);
         wait_all_answered();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d operations and %0d response words under four idling mixes.",
               ops_accepted, words_checked);
      $display("Refused pushes on full: %0d, refused ops on empty: %0d, spare codes: %0d.",
               full_refusals, empty_refusals, unknown_ops);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/dq_pkg.sv
rtl/dq_if.sv
rtl/dq_ctrl.sv
rtl/dq_dpath.sv
rtl/double_ended_queue.sv
rtl/dq_checker.sv
tb/tb_top.sv
